// ===== rtl/core/pia_pkg.sv =====
// Shared types and constants for the primitive index assembler.
package pia_pkg;

   localparam int VERTEX_W = 32;

   // Result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // Mode codes
   localparam logic [2:0] OP_TRI_LIST   = 3'd0;
   localparam logic [2:0] OP_TRI_FAN    = 3'd1;
   localparam logic [2:0] OP_TRI_STRIP  = 3'd2;
   localparam logic [2:0] OP_LINE_LIST  = 3'd3;
   localparam logic [2:0] OP_LINE_STRIP = 3'd4;
   localparam logic [2:0] OP_LINE_LOOP  = 3'd5;
   localparam logic [2:0] OP_POINTS     = 3'd6;
   localparam logic [2:0] OP_RESERVED   = 3'd7;

   // Corner counts
   localparam logic [1:0] CORNERS_POINT = 2'd1;
   localparam logic [1:0] CORNERS_LINE  = 2'd2;
   localparam logic [1:0] CORNERS_TRI   = 2'd3;

   typedef struct packed {
      logic [2:0]          op;
      logic [VERTEX_W-1:0] vertex_index;
      logic                start_of_draw;
      logic                end_of_draw;
   } req_type;

   typedef struct packed {
      logic [VERTEX_W-1:0] corner_a;
      logic [VERTEX_W-1:0] corner_b;
      logic [VERTEX_W-1:0] corner_c;
      logic [1:0]          corners;
      logic                last_of_run;
   } rsp_type;

   // Primitives produced by one vertex, handed to the result queue
   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } push_type;

endpackage

// ===== rtl/core/primitive_index_assembler.sv =====
// Primitive index assembler: vertex index stream in, indexed primitives out.
// The primitives of an accepted vertex are registered in the result queue and offered on rsp in order.
// Throughput: one vertex per cycle; a closing line loop vertex queues two results,
// and the four-entry result queue accepts a vertex while at least two slots are free.
// Reset: synchronous, clears assembly state and empties the result queue.
module primitive_index_assembler #(
   parameter int INDEX_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pia_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pia_pkg::rsp_type  rsp_data
);

   logic                            req_accept;
   logic                            rsp_pop;
   pia_pkg::push_type               push;
   logic [pia_pkg::RSP_CNT_W-1:0]   queue_count;

   assign req_ready  = !reset &&
                       (queue_count <= pia_pkg::RSP_CNT_W'(pia_pkg::RSP_DEPTH - 2));
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = !reset && (queue_count != '0);
   assign rsp_pop    = rsp_valid && rsp_ready;

   pia_assemble #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_assemble (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .req    (req_data),
      .push   (push)
   );

   pia_result_fifo u_result_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (rsp_pop),
      .head  (rsp_data),
      .count (queue_count)
   );

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= pia_pkg::RSP_CNT_W'(pia_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   a_point_one_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.op == pia_pkg::OP_POINTS && !rsp_pop)
      |=> queue_count == $past(queue_count) + pia_pkg::RSP_CNT_W'(1))
      else $error("point vertex did not queue exactly one result");

   a_bad_mode_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.op == pia_pkg::OP_RESERVED && !rsp_pop)
      |=> $stable(queue_count))
      else $error("undefined mode produced a result");

   a_last_flag_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.corners == pia_pkg::CORNERS_POINT) |-> rsp_data.last_of_run)
      else $error("point result without last_of_run");

endmodule

// ===== rtl/core/pia_assemble.sv =====
// Assembly state and primitive generation for one accepted vertex.
module pia_assemble #(
   parameter int INDEX_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  pia_pkg::req_type   req,
   output pia_pkg::push_type  push
);

   logic [INDEX_WIDTH-1:0] anchor_ff, anchor_in;
   logic [INDEX_WIDTH-1:0] older_ff, older_in;
   logic [INDEX_WIDTH-1:0] newer_ff, newer_in;
   logic [1:0]             seen_ff, seen_in;
   logic                   parity_ff, parity_in;

   logic [INDEX_WIDTH-1:0] v;
   logic [INDEX_WIDTH-1:0] anchor_eff;
   logic [1:0]             seen_eff;
   logic                   parity_eff;
   logic [1:0]             seen_next;
   logic                   parity_next;
   pia_pkg::push_type      result;

   function automatic pia_pkg::rsp_type make_rsp(
      input logic [INDEX_WIDTH-1:0] a,
      input logic [INDEX_WIDTH-1:0] b,
      input logic [INDEX_WIDTH-1:0] c,
      input logic [1:0]             n
   );
      pia_pkg::rsp_type r;
      r.corner_a    = pia_pkg::VERTEX_W'(a);
      r.corner_b    = pia_pkg::VERTEX_W'(b);
      r.corner_c    = pia_pkg::VERTEX_W'(c);
      r.corners     = n;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   assign v = req.vertex_index[INDEX_WIDTH-1:0];

   always_comb begin
      anchor_eff  = req.start_of_draw ? v : anchor_ff;
      seen_eff    = req.start_of_draw ? 2'd0 : seen_ff;
      parity_eff  = req.start_of_draw ? 1'b0 : parity_ff;
      seen_next   = seen_eff;
      parity_next = parity_eff;
      result      = '0;

      unique case (req.op)
         pia_pkg::OP_TRI_LIST: begin
            if (seen_eff == 2'd2) begin
               result.item0 = make_rsp(older_ff, newer_ff, v, pia_pkg::CORNERS_TRI);
               result.count = 2'd1;
               seen_next    = 2'd0;
            end else begin
               seen_next = seen_eff + 2'd1;
            end
         end
         pia_pkg::OP_TRI_FAN: begin
            if (seen_eff >= 2'd2) begin
               result.item0 = make_rsp(anchor_eff, newer_ff, v, pia_pkg::CORNERS_TRI);
               result.count = 2'd1;
            end
            if (seen_eff != 2'd3) seen_next = seen_eff + 2'd1;
         end
         pia_pkg::OP_TRI_STRIP: begin
            if (seen_eff >= 2'd2) begin
               // odd triangles swap the last two corners to keep winding
               if (!parity_eff)
                  result.item0 = make_rsp(older_ff, newer_ff, v, pia_pkg::CORNERS_TRI);
               else
                  result.item0 = make_rsp(older_ff, v, newer_ff, pia_pkg::CORNERS_TRI);
               result.count = 2'd1;
               parity_next  = ~parity_eff;
            end
            if (seen_eff != 2'd3) seen_next = seen_eff + 2'd1;
         end
         pia_pkg::OP_LINE_LIST: begin
            if (seen_eff == 2'd1) begin
               result.item0 = make_rsp(newer_ff, v, '0, pia_pkg::CORNERS_LINE);
               result.count = 2'd1;
               seen_next    = 2'd0;
            end else begin
               seen_next = 2'd1;
            end
         end
         pia_pkg::OP_LINE_STRIP, pia_pkg::OP_LINE_LOOP: begin
            if (seen_eff != 2'd0) begin
               result.item0 = make_rsp(newer_ff, v, '0, pia_pkg::CORNERS_LINE);
               result.count = 2'd1;
               if (req.op == pia_pkg::OP_LINE_LOOP && req.end_of_draw) begin
                  result.item1 = make_rsp(v, anchor_eff, '0, pia_pkg::CORNERS_LINE);
                  result.count = 2'd2;
               end
            end
            if (seen_eff != 2'd3) seen_next = seen_eff + 2'd1;
         end
         pia_pkg::OP_POINTS: begin
            result.item0 = make_rsp(v, '0, '0, pia_pkg::CORNERS_POINT);
            result.count = 2'd1;
         end
         default: begin
            result = '0;
         end
      endcase

      if (result.count == 2'd2) result.item1.last_of_run = 1'b1;
      else if (result.count == 2'd1) result.item0.last_of_run = 1'b1;
   end

   // undefined mode leaves the state untouched
   always_comb begin
      anchor_in = anchor_ff;
      older_in  = older_ff;
      newer_in  = newer_ff;
      seen_in   = seen_ff;
      parity_in = parity_ff;
      push      = '0;
      if (accept && req.op != pia_pkg::OP_RESERVED) begin
         anchor_in = anchor_eff;
         older_in  = newer_ff;
         newer_in  = v;
         seen_in   = req.end_of_draw ? 2'd0 : seen_next;
         parity_in = req.end_of_draw ? 1'b0 : parity_next;
         push      = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff <= '0;
         older_ff  <= '0;
         newer_ff  <= '0;
         seen_ff   <= '0;
         parity_ff <= 1'b0;
      end else begin
         anchor_ff <= anchor_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
         seen_ff   <= seen_in;
         parity_ff <= parity_in;
      end
   end

endmodule

// ===== rtl/core/pia_result_fifo.sv =====
// Result queue: takes up to two primitives per cycle, hands out one.
module pia_result_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  pia_pkg::push_type               push,
   input  logic                            pop,
   output pia_pkg::rsp_type                head,
   output logic [pia_pkg::RSP_CNT_W-1:0]   count
);

   pia_pkg::rsp_type                entry_ff [pia_pkg::RSP_DEPTH];
   logic [pia_pkg::RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [pia_pkg::RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [pia_pkg::RSP_CNT_W-1:0]   count_ff, count_in;
   logic [pia_pkg::RSP_PTR_W-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + pia_pkg::RSP_PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + pia_pkg::RSP_PTR_W'(push.count);
   assign rd_ptr_in   = rd_ptr_ff + pia_pkg::RSP_PTR_W'(pop);
   assign count_in    = count_ff + pia_pkg::RSP_CNT_W'(push.count)
                        - pia_pkg::RSP_CNT_W'(pop);

   assign head  = entry_ff[rd_ptr_ff];
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.item0;
      if (push.count == 2'd2) entry_ff[wr_ptr_next] <= push.item1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== tb/tb_primitive_index_assembler.sv =====
// Self-checking testbench for the primitive index assembler.
module tb_primitive_index_assembler;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          INDEX_WIDTH = 32;
   localparam logic [pia_pkg::VERTEX_W-1:0] INDEX_MASK =
      pia_pkg::VERTEX_W'((64'd1 << INDEX_WIDTH) - 64'd1);
   localparam int          USE_MODEL   = -1;
   localparam int          ITEMS_PER_PHASE = 517;

   typedef struct {
      pia_pkg::req_type item;
      int               fixed_n;   // USE_MODEL: expectation comes from the predictor
      pia_pkg::rsp_type fixed0;
      pia_pkg::rsp_type fixed1;
      int               phase;
   } vertex_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pia_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pia_pkg::rsp_type rsp_data;

   vertex_row_type   vertex_rows[$];
   pia_pkg::rsp_type pending_prims[$];
   int               next_row = 0;
   int               error_count = 0;

   // predictor state
   logic [pia_pkg::VERTEX_W-1:0] anchor_v = '0;
   logic [pia_pkg::VERTEX_W-1:0] older_v  = '0;
   logic [pia_pkg::VERTEX_W-1:0] newer_v  = '0;
   logic [1:0]                   seen_cnt = '0;
   logic                         parity   = 1'b0;

   primitive_index_assembler #(
      .INDEX_WIDTH(INDEX_WIDTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic pia_pkg::req_type make_req(input logic [2:0] op,
                                                 input logic [pia_pkg::VERTEX_W-1:0] v,
                                                 input logic s, input logic e);
      pia_pkg::req_type r;
      r.op            = op;
      r.vertex_index  = v;
      r.start_of_draw = s;
      r.end_of_draw   = e;
      return r;
   endfunction

   function automatic pia_pkg::rsp_type make_prim(input logic [pia_pkg::VERTEX_W-1:0] a, b, c,
                                                  input logic [1:0] k, input logic last);
      pia_pkg::rsp_type p;
      p.corner_a    = a;
      p.corner_b    = b;
      p.corner_c    = c;
      p.corners     = k;
      p.last_of_run = last;
      return p;
   endfunction

   function automatic void add_row(input pia_pkg::req_type item, input int fixed_n,
                                   input pia_pkg::rsp_type f0, input pia_pkg::rsp_type f1,
                                   input int phase);
      vertex_row_type row;
      row.item    = item;
      row.fixed_n = fixed_n;
      row.fixed0  = f0;
      row.fixed1  = f1;
      row.phase   = phase;
      vertex_rows.insert(vertex_rows.size(), row);
   endfunction

   function automatic logic [pia_pkg::VERTEX_W-1:0] random_vertex();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      if (pick < 6) return pia_pkg::VERTEX_W'($urandom_range(15));
      return $urandom;
   endfunction

   // Updates the predictor state (the reserved mode leaves it alone) and returns the number of primitives emitted.
   function automatic int assemble_primitives(input pia_pkg::req_type vtx,
                                              output pia_pkg::rsp_type prim0,
                                              output pia_pkg::rsp_type prim1);
      logic [pia_pkg::VERTEX_W-1:0] v;
      logic [1:0]                   seen;
      pia_pkg::rsp_type             found[2];
      int                           n;
      v        = vtx.vertex_index & INDEX_MASK;
      n        = 0;
      found[0] = '0;
      found[1] = '0;
      prim0    = '0;
      prim1    = '0;
      if (vtx.op == pia_pkg::OP_RESERVED) return 0;
      if (vtx.start_of_draw) begin
         seen_cnt = '0;
         parity   = 1'b0;
         anchor_v = v;
      end
      seen = seen_cnt;
      case (vtx.op)
         pia_pkg::OP_TRI_LIST: begin
            if (seen == 2'd2) begin
               found[n] = make_prim(older_v, newer_v, v, pia_pkg::CORNERS_TRI, 1'b0);
               n++;
               seen = '0;
            end else begin
               seen++;
            end
         end
         pia_pkg::OP_TRI_FAN: begin
            if (seen >= 2'd2) begin
               found[n] = make_prim(anchor_v, newer_v, v, pia_pkg::CORNERS_TRI, 1'b0);
               n++;
            end
            if (seen < 2'd3) seen++;
         end
         pia_pkg::OP_TRI_STRIP: begin
            if (seen >= 2'd2) begin
               // odd triangles swap the last two corners to keep the winding
               if (parity)
                  found[n] = make_prim(older_v, v, newer_v, pia_pkg::CORNERS_TRI, 1'b0);
               else
                  found[n] = make_prim(older_v, newer_v, v, pia_pkg::CORNERS_TRI, 1'b0);
               n++;
               parity = ~parity;
            end
            if (seen < 2'd3) seen++;
         end
         pia_pkg::OP_LINE_LIST: begin
            if (seen == 2'd1) begin
               found[n] = make_prim(newer_v, v, '0, pia_pkg::CORNERS_LINE, 1'b0);
               n++;
               seen = '0;
            end else begin
               seen = 2'd1;
            end
         end
         pia_pkg::OP_LINE_STRIP, pia_pkg::OP_LINE_LOOP: begin
            if (seen >= 2'd1) begin
               found[n] = make_prim(newer_v, v, '0, pia_pkg::CORNERS_LINE, 1'b0);
               n++;
               if (vtx.op == pia_pkg::OP_LINE_LOOP && vtx.end_of_draw) begin
                  found[n] = make_prim(v, anchor_v, '0, pia_pkg::CORNERS_LINE, 1'b0);
                  n++;
               end
            end
            if (seen < 2'd3) seen++;
         end
         default: begin
            found[n] = make_prim(v, '0, '0, pia_pkg::CORNERS_POINT, 1'b0);
            n++;
         end
      endcase
      older_v  = newer_v;
      newer_v  = v;
      seen_cnt = seen;
      if (vtx.end_of_draw) begin
         seen_cnt = '0;
         parity   = 1'b0;
      end
      if (n > 0) found[n-1].last_of_run = 1'b1;
      prim0 = found[0];
      prim1 = found[1];
      return n;
   endfunction

   function automatic void add_random_traffic(input int phase, input int target);
      int         added;
      int         kind;
      int         len;
      logic [2:0] mode;
      logic [2:0] op;
      logic       s;
      logic       e;
      bit         broken;
      added = 0;
      while (added < target) begin
         kind = $urandom_range(99);
         if (kind < 8) begin
            op = 3'($urandom_range(7));
            add_row(make_req(op, random_vertex(), 1'($urandom_range(1)),
                             1'($urandom_range(1))), USE_MODEL, '0, '0, phase);
            if (op != pia_pkg::OP_RESERVED) added++;
         end else begin
            broken = (kind < 20);
            mode   = 3'($urandom_range(6));
            len    = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
            for (int k = 0; k < len; k++) begin
               op = mode;
               s  = (k == 0);
               e  = (k == len - 1);
               if (broken) begin
                  // mode switches, stray marks and missing marks
                  if ($urandom_range(3) == 0) op = 3'($urandom_range(7));
                  if (k == 0 || $urandom_range(9) == 0) s = 1'($urandom_range(1));
                  if (k == len - 1 || $urandom_range(9) == 0) e = 1'($urandom_range(1));
               end
               add_row(make_req(op, random_vertex(), s, e), USE_MODEL, '0, '0, phase);
               if (op != pia_pkg::OP_RESERVED) added++;
            end
         end
      end
   endfunction

   task automatic check_field(input string name, input logic [pia_pkg::VERTEX_W-1:0] exp_val,
                              input logic [pia_pkg::VERTEX_W-1:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : handshake
      int               ph;
      int               n;
      int               idle_pct;
      int               stall_pct;
      pia_pkg::rsp_type p0;
      pia_pkg::rsp_type p1;
      pia_pkg::rsp_type want;
      vertex_row_type   row;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            row = vertex_rows[next_row];
            n   = assemble_primitives(row.item, p0, p1);
            if (row.fixed_n == USE_MODEL) begin
               if (n > 0) pending_prims.insert(pending_prims.size(), p0);
               if (n > 1) pending_prims.insert(pending_prims.size(), p1);
            end else begin
               if (row.fixed_n > 0) pending_prims.insert(pending_prims.size(), row.fixed0);
               if (row.fixed_n > 1) pending_prims.insert(pending_prims.size(), row.fixed1);
            end
            next_row++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_prims.size() == 0) begin
               $display("%0t: unexpected primitive, expected none, actual %h", $time, rsp_data);
               error_count++;
            end else begin
               want = pending_prims.pop_front();
               check_field("corner_a", want.corner_a, rsp_data.corner_a);
               check_field("corner_b", want.corner_b, rsp_data.corner_b);
               check_field("corner_c", want.corner_c, rsp_data.corner_c);
               check_field("corners", pia_pkg::VERTEX_W'(want.corners),
                           pia_pkg::VERTEX_W'(rsp_data.corners));
               check_field("last_of_run", pia_pkg::VERTEX_W'(want.last_of_run),
                           pia_pkg::VERTEX_W'(rsp_data.last_of_run));
            end
         end
         ph = vertex_rows[(next_row < vertex_rows.size()) ? next_row
                                                          : vertex_rows.size() - 1].phase;
         case (ph)
            0:       begin idle_pct = 21; stall_pct = 65; end
            1:       begin idle_pct = 65; stall_pct = 21; end
            default: begin idle_pct = 0;  stall_pct = 0;  end
         endcase
         // hold a pending transaction; otherwise offer the next vertex or idle
         if (!req_valid || req_ready) begin
            if (next_row < vertex_rows.size() && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= vertex_rows[next_row].item;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      // extremes and the reserved mode
      add_row(make_req(pia_pkg::OP_POINTS, '0, 1'b1, 1'b1), 1,
              make_prim('0, '0, '0, pia_pkg::CORNERS_POINT, 1'b1), '0, 0);
      add_row(make_req(pia_pkg::OP_POINTS, '1, 1'b1, 1'b1), 1,
              make_prim('1, '0, '0, pia_pkg::CORNERS_POINT, 1'b1), '0, 0);
      add_row(make_req(pia_pkg::OP_RESERVED, 32'h1234_5678, 1'b1, 1'b1), 0, '0, '0, 0);
      // triangle list
      add_row(make_req(pia_pkg::OP_TRI_LIST, '0, 1'b1, 1'b0), 0, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_TRI_LIST, '1, 1'b0, 1'b0), 0, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_TRI_LIST, 32'd1, 1'b0, 1'b1), 1,
              make_prim('0, '1, 32'd1, pia_pkg::CORNERS_TRI, 1'b1), '0, 0);
      // fan
      add_row(make_req(pia_pkg::OP_TRI_FAN, 32'd10, 1'b1, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_TRI_FAN, 32'd11, 1'b0, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_TRI_FAN, 32'd12, 1'b0, 1'b1), USE_MODEL, '0, '0, 0);
      // strip, covers both windings
      add_row(make_req(pia_pkg::OP_TRI_STRIP, 32'd20, 1'b1, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_TRI_STRIP, 32'd21, 1'b0, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_TRI_STRIP, 32'd22, 1'b0, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_TRI_STRIP, 32'd23, 1'b0, 1'b1), USE_MODEL, '0, '0, 0);
      // line list with a dropped trailing vertex
      add_row(make_req(pia_pkg::OP_LINE_LIST, 32'd30, 1'b1, 1'b0), 0, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_LINE_LIST, 32'd31, 1'b0, 1'b0), 1,
              make_prim(32'd30, 32'd31, '0, pia_pkg::CORNERS_LINE, 1'b1), '0, 0);
      add_row(make_req(pia_pkg::OP_LINE_LIST, 32'd32, 1'b0, 1'b1), USE_MODEL, '0, '0, 0);
      // line strip
      add_row(make_req(pia_pkg::OP_LINE_STRIP, 32'd40, 1'b1, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_LINE_STRIP, 32'd41, 1'b0, 1'b1), USE_MODEL, '0, '0, 0);
      // line loop, last vertex closes back to the first
      add_row(make_req(pia_pkg::OP_LINE_LOOP, 32'd50, 1'b1, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_LINE_LOOP, 32'd51, 1'b0, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_LINE_LOOP, 32'd52, 1'b0, 1'b1), USE_MODEL, '0, '0, 0);
      // single-vertex loop has nothing to close
      add_row(make_req(pia_pkg::OP_LINE_LOOP, 32'd60, 1'b1, 1'b1), 0, '0, '0, 0);
      // no start mark, mode changes and a reserved op mid-draw
      add_row(make_req(pia_pkg::OP_TRI_STRIP, 32'd81, 1'b0, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_RESERVED, '1, 1'b0, 1'b0), 0, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_LINE_STRIP, 32'd82, 1'b0, 1'b0), USE_MODEL, '0, '0, 0);
      add_row(make_req(pia_pkg::OP_TRI_FAN, 32'd83, 1'b0, 1'b1), USE_MODEL, '0, '0, 0);

      for (int ph = 0; ph < 3; ph++) add_random_traffic(ph, ITEMS_PER_PHASE);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (next_row < vertex_rows.size()) @(posedge clock);
      while (pending_prims.size() != 0) @(posedge clock);
      // catch stray primitives after the last expected one
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
